>>> rtl/kbmc_pkg.sv
// Package for the k-way balance move checker.
// Holds the item structs, command and verdict codes, and cell control types.
// No dependencies; imported by every module in rtl/.
package kbmc_pkg;

    // Fixed field widths.
    localparam int CMD_W       = 3;
    localparam int PART_W      = 4;
    localparam int MWEIGHT_W   = 16;
    localparam int NUM_PARTS_W = 5;
    localparam int LBOUND_W    = 31;
    localparam int CFG_DATA_W  = 31;
    localparam int CFG_INDEX_W = 1;

    // Command codes. Codes 5 to 7 mean nothing and are ignored.
    localparam logic [CMD_W-1:0] CMD_LOAD       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FINISH     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CHECK      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CONSTRAINT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MOVE       = 3'd4;

    // Verdict codes of a legality check.
    localparam logic [1:0] VERDICT_REJECT  = 2'd0;
    localparam logic [1:0] VERDICT_ILLEGAL = 2'd1;
    localparam logic [1:0] VERDICT_OK      = 2'd2;

    // Verdict codes of a constraint check.
    localparam logic [1:0] CONSTR_FAIL = 2'd0;
    localparam logic [1:0] CONSTR_PASS = 2'd1;

    // Result kinds.
    localparam logic KIND_LEGAL      = 1'b0;
    localparam logic KIND_CONSTRAINT = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_NUM_PARTS   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LOWER_BOUND = 1'd1;

    // Reset value of the part count.
    localparam logic [NUM_PARTS_W-1:0] NUM_PARTS_RESET = 5'd2;

    // One input item.
    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [PART_W-1:0]    from_part;
        logic [PART_W-1:0]    to_part;
        logic [MWEIGHT_W-1:0] module_weight;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [1:0] verdict;
        logic       kind;
    } t_out_item;

    // Broadcast control from the grading logic to every part cell.
    typedef struct packed {
        logic add_to;      // add the weight to the target part
        logic sub_from;    // subtract the weight from the source part
        logic finish;      // recompute the illegal flags
        logic clear_pair;  // clear the flags of source and target
    } t_cell_ctl;

    // Status returned by each part cell, already gated by its part match.
    typedef struct packed {
        logic from_low;    // source total minus weight is below the bound
        logic to_low;      // target total plus weight is below the bound
        logic other_flag;  // active, flagged, and neither source nor target
    } t_cell_stat;

endpackage

>>> rtl/kbmc_part_cell.sv
// One part of the balance checker: its weight total and illegal flag.
// Updates itself from the broadcast control and reports its compares.
// Depends on kbmc_pkg.
module kbmc_part_cell
    import kbmc_pkg::*;
#(
    parameter int IDX          = 0,
    parameter int KW           = 5,
    parameter int WEIGHT_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cell_ctl               i_ctl,
    input  logic [KW-1:0]           i_from,
    input  logic [KW-1:0]           i_to,
    input  logic [KW-1:0]           i_k,
    input  logic [MWEIGHT_W-1:0]    i_weight,
    input  logic [LBOUND_W-1:0]     i_lower_bound,
    output t_cell_stat              o_stat
);

    // Compare width: holds a total with the weight added or removed, and the bound.
    localparam int EW = ((WEIGHT_WIDTH > 32) ? WEIGHT_WIDTH : 32) + 2;
    localparam logic [KW-1:0] MY_IDX = KW'(IDX);

    logic [WEIGHT_WIDTH-1:0] r_weight;
    logic [WEIGHT_WIDTH-1:0] n_weight;
    logic                    r_illegal;
    logic                    n_illegal;

    logic                    is_from;
    logic                    is_to;
    logic                    active;
    logic [WEIGHT_WIDTH-1:0] w_short;
    logic signed [EW-1:0]    tot_e;
    logic signed [EW-1:0]    w_e;
    logic signed [EW-1:0]    lb_e;
    logic                    below_cur;
    logic                    below_sub;
    logic                    below_add;

    // Part match and activity.
    assign is_from = (i_from == MY_IDX);
    assign is_to   = (i_to == MY_IDX);
    assign active  = (MY_IDX < i_k);

    // Exact compares against the bound, without wrap.
    assign w_short   = WEIGHT_WIDTH'(i_weight);
    assign tot_e     = EW'($signed(r_weight));
    assign w_e       = $signed(EW'(i_weight));
    assign lb_e      = $signed(EW'(i_lower_bound));
    assign below_cur = (tot_e < lb_e);
    assign below_sub = ((tot_e - w_e) < lb_e);
    assign below_add = ((tot_e + w_e) < lb_e);

    // Status toward the grading logic.
    assign o_stat.from_low   = is_from & below_sub;
    assign o_stat.to_low     = is_to & below_add;
    assign o_stat.other_flag = r_illegal & active & ~is_from & ~is_to;

    // Next total and flag.
    always_comb begin
        n_weight = r_weight;
        if (i_ctl.add_to && is_to) begin
            n_weight = n_weight + w_short;
        end
        if (i_ctl.sub_from && is_from) begin
            n_weight = n_weight - w_short;
        end

        n_illegal = r_illegal;
        if (i_ctl.finish) begin
            n_illegal = active & below_cur;
        end else if (i_ctl.clear_pair && (is_from || is_to)) begin
            n_illegal = 1'b0;
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight  <= '0;
            r_illegal <= 1'b0;
        end else begin
            r_weight  <= n_weight;
            r_illegal <= n_illegal;
        end
    end

endmodule

>>> rtl/kway_balance_move_checker.sv
// Top level of the k-way balance move checker.
// Holds the configuration, input and result registers and the grading logic.
// Depends on kbmc_pkg and kbmc_part_cell.
//
// Usage:
//   Items enter on i_item when i_start is high; o_busy is always low, so an
//   item is taken at every edge where i_start is high. Load and move items
//   update the part totals, finish recomputes the illegal flags, and the two
//   check commands each produce one result item on o_result, marked by
//   o_strobe for exactly one cycle. Other commands produce no result.
//   A check passes through one input register and then one result register
//   before its result is shown. Throughput: one item per cycle. Each part is
//   its own cell with its own add and subtract logic and three compares, so
//   every command completes in the cycle after it is registered and the next
//   item sees the updated totals. Configuration: i_cfg_we writes i_cfg_data
//   into register i_cfg_index (0 part count, 1 lower bound) at the clock edge;
//   the user must write only while no item is in flight, which the block does
//   not enforce. Reset (synchronous, active low) clears all totals and flags,
//   sets the part count to 2 and the bound to 0. The receiver cannot stall;
//   each result must be taken in the cycle it is shown.
module kway_balance_move_checker
    import kbmc_pkg::*;
#(
    parameter int MAX_PARTS    = 16,
    parameter int WEIGHT_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    output logic                   o_busy,
    input  t_in_item               i_item,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output logic                   o_strobe,
    output t_out_item              o_result
);

    // Width for part indexes and counts; holds MAX_PARTS and any num_parts value.
    localparam int KW = ($clog2(MAX_PARTS + 1) > NUM_PARTS_W) ?
                        $clog2(MAX_PARTS + 1) : NUM_PARTS_W;
    localparam logic [KW-1:0] MAX_K = KW'(MAX_PARTS);

    logic [NUM_PARTS_W-1:0] r_num_parts;
    logic [LBOUND_W-1:0]    r_lower_bound;
    logic                   r_valid;
    t_in_item               r_item;
    logic                   r_strobe;
    t_out_item              r_result;
    logic                   n_strobe;
    t_out_item              n_result;

    logic [KW-1:0]          num_parts_x;
    logic [KW-1:0]          k_active;
    logic [KW-1:0]          from_x;
    logic [KW-1:0]          to_x;
    logic                   from_ok;
    logic                   to_ok;
    logic                   any_from_low;
    logic                   any_to_low;
    logic                   any_other;
    logic                   grade_ok;
    t_cell_ctl              cell_ctl;

    logic [MAX_PARTS-1:0]   from_low_vec;
    logic [MAX_PARTS-1:0]   to_low_vec;
    logic [MAX_PARTS-1:0]   other_vec;

    assign o_busy   = 1'b0;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_parts   <= NUM_PARTS_RESET;
            r_lower_bound <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_NUM_PARTS: begin
                    r_num_parts <= i_cfg_data[NUM_PARTS_W-1:0];
                end
                REG_LOWER_BOUND: begin
                    r_lower_bound <= i_cfg_data[LBOUND_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_item <= i_item;
        end
    end

    // Active part count and index range checks.
    assign num_parts_x = KW'(r_num_parts);
    assign k_active    = (num_parts_x > MAX_K) ? MAX_K : num_parts_x;
    assign from_x      = KW'(r_item.from_part);
    assign to_x        = KW'(r_item.to_part);
    assign from_ok     = (from_x < k_active);
    assign to_ok       = (to_x < k_active);

    // Part cells.
    for (genvar g = 0; g < MAX_PARTS; g++) begin : g_part
        t_cell_stat stat;

        kbmc_part_cell #(
            .IDX          (g),
            .KW           (KW),
            .WEIGHT_WIDTH (WEIGHT_WIDTH)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (cell_ctl),
            .i_from        (from_x),
            .i_to          (to_x),
            .i_k           (k_active),
            .i_weight      (r_item.module_weight),
            .i_lower_bound (r_lower_bound),
            .o_stat        (stat)
        );

        assign from_low_vec[g] = stat.from_low;
        assign to_low_vec[g]   = stat.to_low;
        assign other_vec[g]    = stat.other_flag;
    end

    assign any_from_low = |from_low_vec;
    assign any_to_low   = |to_low_vec;
    assign any_other    = |other_vec;
    assign grade_ok     = from_ok & to_ok & ~any_from_low & ~any_to_low;

    // Grading and cell control.
    always_comb begin
        cell_ctl = '0;
        n_strobe = 1'b0;
        n_result = '0;
        if (r_valid) begin
            case (r_item.cmd)
                CMD_LOAD: begin
                    cell_ctl.add_to = to_ok;
                end
                CMD_FINISH: begin
                    cell_ctl.finish = 1'b1;
                end
                CMD_CHECK: begin
                    n_strobe      = 1'b1;
                    n_result.kind = KIND_LEGAL;
                    if (!from_ok || !to_ok || any_from_low) begin
                        n_result.verdict = VERDICT_REJECT;
                    end else if (any_to_low || any_other) begin
                        n_result.verdict = VERDICT_ILLEGAL;
                    end else begin
                        n_result.verdict = VERDICT_OK;
                    end
                    cell_ctl.clear_pair = grade_ok;
                end
                CMD_CONSTRAINT: begin
                    n_strobe         = 1'b1;
                    n_result.kind    = KIND_CONSTRAINT;
                    n_result.verdict = (from_ok && !any_from_low) ? CONSTR_PASS : CONSTR_FAIL;
                end
                CMD_MOVE: begin
                    cell_ctl.add_to   = from_ok & to_ok;
                    cell_ctl.sub_from = from_ok & to_ok;
                end
                default: begin
                end
            endcase
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

endmodule

>>> tb/kway_balance_move_checker_tb.sv
// Self-checking testbench for the k-way balance move checker.
// It drives command items and writes the part count and lower bound between phases,
// and it checks every verdict against its own model of the part totals and flags.
// Depends on kbmc_pkg and the kway_balance_move_checker RTL.
module kway_balance_move_checker_tb;
    import kbmc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PARTS      = 16;
    localparam int WEIGHT_W       = 32;
    localparam int RESET_CYCLES   = 7;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TOTAL_ITEMS    = 800;
    localparam int CALM_START     = 680;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam longint BOUND_MAX  = 64'h7FFF_FFFF;
    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = CMD_MOVE + 3'd1;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_start = 1'b0;
    logic                   o_busy;
    t_in_item               i_item = '0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   o_strobe;
    t_out_item              o_result;

    // Model state: part totals, illegal flags and the two registers.
    logic signed [WEIGHT_W-1:0] part_total [MAX_PARTS];
    bit                         part_flag [MAX_PARTS];
    logic [NUM_PARTS_W-1:0]     cfg_parts;
    logic [LBOUND_W-1:0]        cfg_bound;

    t_in_item  item_q [$];     // items waiting to be driven
    t_out_item verdict_q [$];  // verdicts still owed by the block

    int  mismatches = 0;
    int  quiet_cycles = 0;
    int  gap_left = 0;
    int  items_sent = 0;
    bit  idle_on = 1'b1;
    bit  taken = 1'b0;

    kway_balance_move_checker #(
        .MAX_PARTS    (MAX_PARTS),
        .WEIGHT_WIDTH (WEIGHT_W)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Apply one item to the model and return whether it yields a verdict.
    function automatic bit grade_item(input t_in_item it, output t_out_item res);
        int     kk;
        int     i;
        bit     from_ok;
        bit     to_ok;
        longint lb;
        longint w;
        longint from_tot;
        longint to_tot;
        kk = (cfg_parts > MAX_PARTS) ? MAX_PARTS : int'(cfg_parts);
        from_ok = it.from_part < kk;
        to_ok = it.to_part < kk;
        lb = longint'(cfg_bound);
        w = longint'(it.module_weight);
        from_tot = longint'(part_total[it.from_part]);
        to_tot = longint'(part_total[it.to_part]);
        res = '0;
        grade_item = 1'b0;
        case (it.cmd)
            CMD_LOAD: begin
                if (to_ok)
                    part_total[it.to_part] = part_total[it.to_part] + it.module_weight;
            end
            CMD_FINISH: begin
                for (i = 0; i < MAX_PARTS; i++)
                    part_flag[i] = (i < kk) && (longint'(part_total[i]) < lb);
            end
            CMD_CHECK: begin
                res.kind = KIND_LEGAL;
                grade_item = 1'b1;
                if (!from_ok || !to_ok || from_tot - w < lb) begin
                    res.verdict = VERDICT_REJECT;
                end else if (to_tot + w < lb) begin
                    res.verdict = VERDICT_ILLEGAL;
                end else begin
                    // Clear the pair first, then any other flagged part still counts.
                    part_flag[it.from_part] = 1'b0;
                    part_flag[it.to_part] = 1'b0;
                    res.verdict = VERDICT_OK;
                    for (i = 0; i < kk; i++)
                        if (part_flag[i])
                            res.verdict = VERDICT_ILLEGAL;
                end
            end
            CMD_CONSTRAINT: begin
                res.kind = KIND_CONSTRAINT;
                res.verdict = (from_ok && from_tot - w >= lb) ? CONSTR_PASS : CONSTR_FAIL;
                grade_item = 1'b1;
            end
            CMD_MOVE: begin
                if (from_ok && to_ok) begin
                    part_total[it.to_part] = part_total[it.to_part] + it.module_weight;
                    part_total[it.from_part] = part_total[it.from_part] - it.module_weight;
                end
            end
            default: begin
            end
        endcase
    endfunction

    // Model update, result check and watchdog, all at the rising edge.
    always @(posedge i_clk) begin
        t_out_item pred;
        t_out_item want;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_PARTS; i++) begin
                part_total[i] = '0;
                part_flag[i] = 1'b0;
            end
            cfg_parts = NUM_PARTS_RESET;
            cfg_bound = '0;
            taken = 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_NUM_PARTS)
                    cfg_parts = i_cfg_data[NUM_PARTS_W-1:0];
                else if (i_cfg_index == REG_LOWER_BOUND)
                    cfg_bound = i_cfg_data[LBOUND_W-1:0];
            end

            taken = i_start && !o_busy;
            if (taken && grade_item(i_item, pred))
                verdict_q.push_back(pred);

            if (o_strobe) begin
                if (verdict_q.size() == 0) begin
                    if (mismatches < MAX_REPORTS)
                        $display("%0t: unexpected result verdict %0d kind %0d", $realtime,
                                 o_result.verdict, o_result.kind);
                    mismatches++;
                end else begin
                    want = verdict_q.pop_front();
                    if (o_result.verdict !== want.verdict || o_result.kind !== want.kind) begin
                        if (mismatches < MAX_REPORTS)
                            $display({"%0t: wrong result: expected verdict %0d kind %0d, ",
                                      "got verdict %0d kind %0d"},
                                     $realtime, want.verdict, want.kind,
                                     o_result.verdict, o_result.kind);
                        mismatches++;
                    end
                end
            end

            if (taken || o_strobe || i_cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("kway_balance_move_checker: mismatch");
                $finish;
            end
        end
    end

    // Item driver: holds an item until taken, with random bursts of idle cycles.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (i_start && !taken) begin
            i_start <= 1'b1;
        end else if (gap_left != 0) begin
            gap_left--;
            i_start <= 1'b0;
        end else if (item_q.size() != 0) begin
            i_item <= item_q.pop_front();
            i_start <= 1'b1;
            if (idle_on && $urandom_range(0, 5) == 0)
                gap_left = $urandom_range(1, 12);
        end else begin
            i_start <= 1'b0;
        end
    end

    task automatic queue_item(input logic [CMD_W-1:0] cmd, input int from_p, input int to_p,
                              input int wt);
        t_in_item it;
        it.cmd = cmd;
        it.from_part = PART_W'(from_p);
        it.to_part = PART_W'(to_p);
        it.module_weight = MWEIGHT_W'(wt);
        item_q.push_back(it);
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input longint val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= CFG_DATA_W'(val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait until every item is taken and every verdict has come, then let
    // the pipeline empty out for items that give no verdict.
    task automatic wait_drained();
        while (item_q.size() != 0 || i_start || verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // A part index, mostly one of the active parts.
    function automatic int pick_part(input int kk);
        if (kk > 0 && $urandom_range(0, 15) != 0)
            return $urandom_range(0, kk - 1);
        return $urandom_range(0, 15);
    endfunction

    // One random phase: new registers, a load pass, finish, then checks and moves.
    task automatic run_phase(input int n_body);
        int     k_val;
        int     kk;
        int     n_loads;
        int     i;
        int     r;
        int     from_p;
        int     to_p;
        int     wt;
        int     start_count;
        int     load_part [$];
        int     load_wt [$];
        longint sum;
        longint bound;
        if ($urandom_range(0, 9) < 7)
            k_val = $urandom_range(2, MAX_PARTS);
        else
            k_val = $urandom_range(0, 31);
        kk = (k_val > MAX_PARTS) ? MAX_PARTS : k_val;

        // Plan the loads first so the bound sits near the average part total.
        sum = 0;
        for (i = 0; i < kk; i++)
            sum += longint'(part_total[i]);
        n_loads = $urandom_range(4, 20);
        for (i = 0; i < n_loads; i++) begin
            load_part.push_back(pick_part(kk));
            load_wt.push_back($urandom_range(0, 65535));
            if (load_part[i] < kk)
                sum += load_wt[i];
        end
        if (kk == 0 || sum <= 0)
            bound = $urandom_range(0, 65535);
        else
            bound = sum * $urandom_range(4, 8) / (kk * 8);
        r = $urandom_range(0, 11);
        if (r == 0)
            bound = longint'($urandom) & BOUND_MAX;
        else if (r == 1)
            bound = 0;
        if (bound > BOUND_MAX)
            bound = BOUND_MAX;

        write_reg(REG_NUM_PARTS, k_val);
        write_reg(REG_LOWER_BOUND, bound);

        start_count = items_sent;
        for (i = 0; i < n_loads; i++)
            queue_item(CMD_LOAD, $urandom_range(0, 15), load_part[i], load_wt[i]);
        queue_item(CMD_FINISH, $urandom_range(0, 15), $urandom_range(0, 15), $urandom);

        // Mostly check-then-move sequences, with some stray commands as noise.
        while (items_sent - start_count < n_body) begin
            r = $urandom_range(0, 99);
            from_p = pick_part(kk);
            to_p = pick_part(kk);
            wt = $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 8191);
            if (r < 65) begin
                queue_item(CMD_CHECK, from_p, to_p, wt);
                queue_item(CMD_CONSTRAINT, from_p, to_p, wt);
                if ($urandom_range(0, 4) != 0)
                    queue_item(CMD_MOVE, from_p, to_p, wt);
            end else if (r < 72) begin
                queue_item(CMD_FINISH, from_p, to_p, wt);
            end else if (r < 80) begin
                queue_item(CMD_LOAD, from_p, to_p, wt);
            end else if (r < 88) begin
                queue_item(CMD_MOVE, from_p, to_p, wt);
            end else begin
                queue_item(CMD_W'($urandom_range(0, 7)), $urandom_range(0, 15),
                           $urandom_range(0, 15), $urandom_range(0, 65535));
            end
        end
    endtask

    // Stimulus sequence and end of run.
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: two parts, zero bound.
        queue_item(CMD_CHECK, 0, 1, 0);
        queue_item(CMD_CONSTRAINT, 0, 1, 0);
        queue_item(CMD_CONSTRAINT, 15, 0, 0);      // inactive source part
        queue_item(CMD_CHECK, 0, 15, 0);           // inactive target part
        queue_item(CMD_LOAD, 0, 0, 16'hFFFF);
        queue_item(CMD_LOAD, 0, 9, 1234);          // load to an inactive part is dropped
        queue_item(CMD_MOVE, 0, 1, 16'hAAAA);
        queue_item(CMD_MOVE, 1, 1, 16'h5555);      // same source and target
        queue_item(CMD_MOVE, 1, 0, 16'hFFFF);      // drives part 1 negative
        queue_item(CMD_FINISH, 0, 0, 0);
        queue_item(CMD_CHECK, 0, 1, 0);
        queue_item(CMD_CONSTRAINT, 1, 0, 0);
        for (int c = 0; c < 3; c++)
            queue_item(CMD_SPARE_FIRST + CMD_W'(c), 15, 15, 16'hFFFF);
        queue_item(CMD_MOVE, 15, 0, 100);          // move from an inactive part is dropped
        wait_drained();

        // Part count above the limit and the largest bound: every part is low.
        write_reg(REG_NUM_PARTS, 31);
        write_reg(REG_LOWER_BOUND, BOUND_MAX);
        queue_item(CMD_FINISH, 0, 0, 0);
        queue_item(CMD_CHECK, 0, 15, 0);
        queue_item(CMD_CONSTRAINT, 15, 0, 0);
        wait_drained();

        // No active parts, then a single part.
        write_reg(REG_NUM_PARTS, 0);
        write_reg(REG_LOWER_BOUND, 0);
        queue_item(CMD_CHECK, 0, 0, 0);
        queue_item(CMD_LOAD, 0, 0, 1);
        queue_item(CMD_FINISH, 0, 0, 0);
        wait_drained();
        write_reg(REG_NUM_PARTS, 1);
        queue_item(CMD_CHECK, 0, 0, 0);
        wait_drained();

        while (items_sent < TOTAL_ITEMS) begin
            if (items_sent >= CALM_START)
                idle_on = 1'b0;
            run_phase($urandom_range(40, 120));
            wait_drained();
        end

        if (mismatches == 0)
            $display("kway_balance_move_checker: match");
        else
            $display("kway_balance_move_checker: mismatch");
        $finish;
    end

endmodule
